>>> rtl/core/rsam_pkg.sv
// ----------------------------------------------------------------------------
// rsam_pkg
// Shared types and constants of the radial soft alpha mask.
// ----------------------------------------------------------------------------
package rsam_pkg;

  typedef enum logic [1:0] {
    CfgCenterX     = 2'd0,
    CfgCenterY     = 2'd1,
    CfgInnerRadius = 2'd2,
    CfgOuterRadius = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int unsigned RgbBits     = 24;
  localparam int unsigned QueueDepth  = 4;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [7:0]  AlphaClear  = 8'h00;

endpackage

>>> rtl/core/rsam_front.sv
// ----------------------------------------------------------------------------
// rsam_front
// Crop test and offsets; in-crop pixels go to the work queue, others drop.
// ----------------------------------------------------------------------------
module rsam_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic [COORD_BITS-1:0]   pixel_x_i,
  input  logic [COORD_BITS-1:0]   pixel_y_i,
  input  rsam_pkg::rgb_t          rgb_i,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  input  logic [COORD_BITS-1:0]   outer_radius_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output logic signed [COORD_BITS:0] q_dx_o,
  output logic signed [COORD_BITS:0] q_dy_o,
  output logic [COORD_BITS:0]     q_col_o,
  output logic [COORD_BITS:0]     q_row_o,
  output rsam_pkg::rgb_t          q_rgb_o
);
  import rsam_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;

  logic          valid_q, valid_d;
  logic          accept, in_crop;
  logic [CW-1:0] px, py, cx, cy, r;
  logic [CW-1:0] col_d, row_d;
  logic signed [CW-1:0] dx_q, dy_q;
  logic [CW-1:0] col_q, row_q;
  rgb_t          rgb_q;

  assign px = {1'b0, pixel_x_i};
  assign py = {1'b0, pixel_y_i};
  assign cx = {1'b0, center_x_i};
  assign cy = {1'b0, center_y_i};
  assign r  = {1'b0, outer_radius_i};

  assign in_crop = (px + r >= cx) && (px < cx + r) && (py + r >= cy) && (py < cy + r);
  assign col_d   = (cx >= r) ? px + r - cx : px;
  assign row_d   = (cy >= r) ? py + r - cy : py;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;

  always_comb begin
    valid_d = valid_q;
    if (q_push_o) valid_d = 1'b0;
    if (accept)   valid_d = in_crop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q  <= $signed(px) - $signed(cx);
      dy_q  <= $signed(py) - $signed(cy);
      col_q <= col_d;
      row_q <= row_d;
      rgb_q <= rgb_i;
    end
  end

  assign q_dx_o  = dx_q;
  assign q_dy_o  = dy_q;
  assign q_col_o = col_q;
  assign q_row_o = row_q;
  assign q_rgb_o = rgb_q;

endmodule

>>> rtl/core/rsam_queue.sv
// ----------------------------------------------------------------------------
// rsam_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rsam_queue #(
  parameter int unsigned WIDTH = 76
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import rsam_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> rtl/core/rsam_back.sv
// ----------------------------------------------------------------------------
// rsam_back
// Squares, bit-per-stage square root, alpha classify, bit-per-stage divide.
// ----------------------------------------------------------------------------
module rsam_back #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  input  logic signed [COORD_BITS:0] q_dx_i,
  input  logic signed [COORD_BITS:0] q_dy_i,
  input  logic [COORD_BITS:0]        q_col_i,
  input  logic [COORD_BITS:0]        q_row_i,
  input  rsam_pkg::rgb_t             q_rgb_i,
  input  logic [COORD_BITS-1:0]      inner_radius_i,
  input  logic [COORD_BITS-1:0]      outer_radius_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [COORD_BITS:0]        crop_col_o,
  output logic [COORD_BITS:0]        crop_row_o,
  output rsam_pkg::rgb_t             rgb_o,
  output logic [7:0]                 alpha_o
);
  import rsam_pkg::*;

  localparam int CW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS;
  localparam int DW  = 2 * COORD_BITS + 2;
  localparam int RW  = COORD_BITS + 1 + FRAC_BITS;
  localparam int RMW = RW + 3;
  localparam int FW  = COORD_BITS + FRAC_BITS;
  localparam int NW  = FW + 8;
  localparam int L   = RW + 11;
  localparam int SW  = 2 * CW + RgbBits;

  logic              en;
  logic              v_q    [L+1];
  logic [SW-1:0]     side_q [L+1];
  logic signed [CW-1:0] dx_q, dy_q;
  logic signed [2*CW-1:0] prod_x, prod_y;
  logic [SQW-1:0]    sqx_q, sqy_q;

  logic [DW-1:0]     sq_v    [RW+1];
  logic [RMW-1:0]    sq_rem  [RW+1];
  logic [RW-1:0]     sq_root [RW+1];
  logic [RMW-1:0]    rem_nxt [RW];
  logic [RW-1:0]     root_nxt[RW];

  logic [FW-1:0]     outer_f, inner_f, den, diff;
  logic [RW-1:0]     dist_fx;
  logic              fix_d;
  logic [7:0]        fix_val_d;
  logic [NW-1:0]     num_d;

  logic [NW-1:0]     dv_rem [9];
  logic [7:0]        dv_q   [9];
  logic              dv_flag[9];
  logic [7:0]        dv_fix [9];
  logic [NW-1:0]     dv_rem_nxt[8];
  logic [7:0]        dv_q_nxt  [8];

  assign en      = !v_q[L] || pop_i;
  assign q_pop_o = en && !q_empty_i;
  assign empty_o = !v_q[L];

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  always_comb begin
    logic [1:0]     pair;
    logic [RMW-1:0] remx, trial;
    for (int s = 0; s < RW; s++) begin
      pair = 2'b00;
      if (RW - 1 - s >= FRAC_BITS) begin
        pair = 2'(sq_v[s] >> (2 * (RW - 1 - s - FRAC_BITS)));
      end
      remx  = {sq_rem[s][RMW-3:0], pair};
      trial = RMW'({sq_root[s], 2'b01});
      if (remx >= trial) begin
        rem_nxt[s]  = remx - trial;
        root_nxt[s] = {sq_root[s][RW-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = remx;
        root_nxt[s] = {sq_root[s][RW-2:0], 1'b0};
      end
    end
  end

  assign outer_f = FW'(outer_radius_i) << FRAC_BITS;
  assign inner_f = FW'(inner_radius_i) << FRAC_BITS;
  assign den     = outer_f - inner_f;
  assign dist_fx = sq_root[RW];
  assign diff    = outer_f - dist_fx[FW-1:0];
  assign num_d   = (NW'(diff) << 8) - NW'(diff);

  always_comb begin
    fix_d     = 1'b0;
    fix_val_d = AlphaOpaque;
    if (dist_fx >= {1'b0, outer_f}) begin
      fix_d     = 1'b1;
      fix_val_d = AlphaClear;
    end else if (dist_fx <= {1'b0, inner_f}) begin
      fix_d     = 1'b1;
      fix_val_d = AlphaOpaque;
    end
  end

  always_comb begin
    logic [NW-1:0] trial;
    for (int i = 0; i < 8; i++) begin
      trial         = NW'(den) << (7 - i);
      dv_rem_nxt[i] = dv_rem[i];
      dv_q_nxt[i]   = dv_q[i];
      if (dv_rem[i] >= trial) begin
        dv_rem_nxt[i] = dv_rem[i] - trial;
        dv_q_nxt[i]   = dv_q[i] | (8'd1 << (7 - i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= L; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= q_pop_o;
      for (int i = 1; i <= L; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= {q_col_i, q_row_i, q_rgb_i};
      for (int i = 1; i <= L; i++) side_q[i] <= side_q[i-1];
      dx_q       <= q_dx_i;
      dy_q       <= q_dy_i;
      sqx_q      <= prod_x[SQW-1:0];
      sqy_q      <= prod_y[SQW-1:0];
      sq_v[0]    <= DW'(sqx_q) + DW'(sqy_q);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      for (int s = 0; s < RW; s++) begin
        sq_v[s+1]    <= sq_v[s];
        sq_rem[s+1]  <= rem_nxt[s];
        sq_root[s+1] <= root_nxt[s];
      end
      dv_rem[0]  <= num_d;
      dv_q[0]    <= '0;
      dv_flag[0] <= fix_d;
      dv_fix[0]  <= fix_val_d;
      for (int i = 0; i < 8; i++) begin
        dv_rem[i+1]  <= dv_rem_nxt[i];
        dv_q[i+1]    <= dv_q_nxt[i];
        dv_flag[i+1] <= dv_flag[i];
        dv_fix[i+1]  <= dv_fix[i];
      end
    end
  end

  assign {crop_col_o, crop_row_o, rgb_o} = side_q[L];
  assign alpha_o = dv_flag[8] ? dv_fix[8] : dv_q[8];

endmodule

>>> rtl/core/radial_soft_alpha_mask.sv
// ----------------------------------------------------------------------------
// radial_soft_alpha_mask
// Feathered circular crop: position, passed colour and radial alpha per pixel.
//
//   channel  | dir | handshake          | payload
//   pixel in | in  | push / full        | pixel_x, pixel_y, red/green/blue_in
//   result   | out | empty / pop        | crop_col, crop_row, red/green/blue_out, alpha
//   config   | in  | cfg_we             | cfg_idx, cfg_data
//
// One pixel per cycle sustained while the result side pops. Pixels pass through
// the front register, the queue and the back pipeline; the square root takes one
// stage per root bit and the alpha divide one stage per quotient bit.
// Reset clears the configuration and all valid flags; no clearing pass.
// A held result stalls the whole back pipeline; the front keeps taking pixels
// until the queue fills, and out-of-crop pixels drop in the front.
// ----------------------------------------------------------------------------
module radial_soft_alpha_mask #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS:0]   crop_col_o,
  output logic [COORD_BITS:0]   crop_row_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o
);
  import rsam_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned QW = 4 * CW + RgbBits;

  logic [COORD_BITS-1:0] center_x_q, center_y_q, inner_q, outer_q;
  rgb_t                  rgb_in, rgb_out, f_rgb, b_rgb;
  logic                  f_push, q_full, q_empty, q_pop;
  logic signed [CW-1:0]  f_dx, f_dy, b_dx, b_dy;
  logic [CW-1:0]         f_col, f_row, b_col, b_row;
  logic [QW-1:0]         q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      inner_q    <= '0;
      outer_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCenterX:     center_x_q <= cfg_data_i;
        CfgCenterY:     center_y_q <= cfg_data_i;
        CfgInnerRadius: inner_q    <= cfg_data_i;
        CfgOuterRadius: outer_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rgb_in = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  rsam_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .pixel_x_i, .pixel_y_i, .rgb_i(rgb_in),
    .center_x_i(center_x_q), .center_y_i(center_y_q), .outer_radius_i(outer_q),
    .q_full_i(q_full), .q_push_o(f_push),
    .q_dx_o(f_dx), .q_dy_o(f_dy), .q_col_o(f_col), .q_row_o(f_row), .q_rgb_o(f_rgb)
  );

  assign q_wdata = {f_dx, f_dy, f_col, f_row, f_rgb};

  rsam_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_rdata), .empty_o(q_empty)
  );

  assign {b_dx, b_dy, b_col, b_row, b_rgb} = q_rdata;

  rsam_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_pop_o(q_pop),
    .q_dx_i(b_dx), .q_dy_i(b_dy), .q_col_i(b_col), .q_row_i(b_row), .q_rgb_i(b_rgb),
    .inner_radius_i(inner_q), .outer_radius_i(outer_q),
    .pop_i(pop), .empty_o(empty),
    .crop_col_o, .crop_row_o, .rgb_o(rgb_out), .alpha_o(alpha_out_o)
  );

  assign red_out_o   = rgb_out.red;
  assign green_out_o = rgb_out.green;
  assign blue_out_o  = rgb_out.blue;

  a_col_in_crop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> crop_col_o < {outer_q, 1'b0})
    else $error("crop column beyond crop width");

  a_row_in_crop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> crop_row_o < {outer_q, 1'b0})
    else $error("crop row beyond crop height");

  a_no_ramp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && inner_q >= outer_q) |->
      (alpha_out_o == AlphaOpaque || alpha_out_o == AlphaClear))
    else $error("ramp alpha without ramp band");

endmodule

>>> tb/rsam_checker.sv
// ----------------------------------------------------------------------------
// rsam_checker
// Watches the pixel, result and configuration ports of the radial soft alpha
// mask, predicts each result from its own copy of the registers and compares
// every popped result as a whole with the oldest prediction.
// ----------------------------------------------------------------------------
module rsam_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [12:0] crop_col_i,
  input  logic [12:0] crop_row_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  input  logic [7:0]  alpha_out_i,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsam_pkg::*;

  typedef struct packed {
    logic [12:0] col;
    logic [12:0] row;
    rgb_t        rgb;
    logic [7:0]  alpha;
  } masked_px_t;

  logic [11:0] ctr_x, ctr_y, rad_in, rad_out;
  masked_px_t  masked_q[$];
  int          errs;

  assign err_count_o = errs;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit mask_pixel(logic [11:0] px, logic [11:0] py, rgb_t rgb,
                                    output masked_px_t m);
    longint left, top, dx, dy, cx, cy, r, x, y;
    logic [63:0] dist_fx, of, inf;
    x    = px;
    y    = py;
    cx   = ctr_x;
    cy   = ctr_y;
    r    = rad_out;
    left = (cx - r < 0) ? 0 : cx - r;
    top  = (cy - r < 0) ? 0 : cy - r;
    m    = '0;
    if (x < left || x > cx + r - 1 || y < top || y > cy + r - 1) return 0;
    dx      = x - cx;
    dy      = y - cy;
    dist_fx = floor_sqrt(64'(dx * dx + dy * dy) << 16);
    of      = 64'(rad_out) << 8;
    inf     = 64'(rad_in) << 8;
    if (dist_fx >= of) m.alpha = AlphaClear;
    else if (dist_fx <= inf) m.alpha = AlphaOpaque;
    else m.alpha = 8'(((of - dist_fx) * 255) / (of - inf));
    m.col = 13'(x - left);
    m.row = 13'(y - top);
    m.rgb = rgb;
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    masked_px_t m, e;
    if (!rst_ni) begin
      ctr_x   <= '0;
      ctr_y   <= '0;
      rad_in  <= '0;
      rad_out <= '0;
      masked_q.delete();
      errs = 0;
      pending_o = 0;
    end else begin
      if (push_i && !full_i) begin
        if (mask_pixel(pixel_x_i, pixel_y_i, '{red_in_i, green_in_i, blue_in_i}, m))
          masked_q.push_back(m);
      end
      if (pop_i && !empty_i) begin
        m = '{crop_col_i, crop_row_i, '{red_out_i, green_out_i, blue_out_i}, alpha_out_i};
        if (masked_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: unexpected result %p", $realtime, m);
        end else begin
          e = masked_q.pop_front();
          if (m !== e) begin
            errs++;
            if (errs <= 10) $display("%0t: mismatch expected %p actual %p", $realtime, e, m);
          end
        end
      end
      pending_o = masked_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgCenterX:     ctr_x   <= cfg_data_i;
          CfgCenterY:     ctr_y   <= cfg_data_i;
          CfgInnerRadius: rad_in  <= cfg_data_i;
          CfgOuterRadius: rad_out <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pixels through the radial soft alpha mask under several crop and
// radius settings with random push and pop gaps; the checker predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsam_pkg::*;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [11:0] cfg_data;
  logic        push, full, empty, pop;
  logic [11:0] pixel_x, pixel_y;
  logic [7:0]  red_in, green_in, blue_in;
  logic [12:0] crop_col, crop_row;
  logic [7:0]  red_out, green_out, blue_out, alpha_out;
  int          err_count, pending;
  int          send_idle_pct, recv_idle_pct, hold_left, stall_cnt;
  logic [11:0] cur_cx, cur_cy, cur_out;

  radial_soft_alpha_mask i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .push(push), .full(full), .pixel_x_i(pixel_x),
    .pixel_y_i(pixel_y), .red_in_i(red_in), .green_in_i(green_in),
    .blue_in_i(blue_in), .empty(empty), .pop(pop), .crop_col_o(crop_col),
    .crop_row_o(crop_row), .red_out_o(red_out), .green_out_o(green_out),
    .blue_out_o(blue_out), .alpha_out_o(alpha_out)
  );

  rsam_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .push_i(push), .full_i(full), .pixel_x_i(pixel_x),
    .pixel_y_i(pixel_y), .red_in_i(red_in), .green_in_i(green_in),
    .blue_in_i(blue_in), .empty_i(empty), .pop_i(pop), .crop_col_i(crop_col),
    .crop_row_i(crop_row), .red_out_i(red_out), .green_out_i(green_out),
    .blue_out_i(blue_out), .alpha_out_i(alpha_out), .err_count_o(err_count),
    .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drain_and_settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_mask(logic [11:0] cx, logic [11:0] cy, logic [11:0] ri,
                          logic [11:0] ro);
    logic [11:0] vals[4];
    vals = '{cx, cy, ri, ro};
    push <= 1'b0;
    drain_and_settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cx  = cx;
    cur_cy  = cy;
    cur_out = ro;
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [23:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    {red_in, green_in, blue_in} <= rgb;
    do @(posedge clk); while (full);
  endtask

  function automatic logic [11:0] near_axis(logic [11:0] c);
    longint lo, hi;
    lo = longint'(c) - cur_out - 2;
    hi = longint'(c) + cur_out + 1;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    return 12'($urandom_range(int'(hi), int'(lo)));
  endfunction

  task automatic send_random(int n);
    logic [11:0] x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        x = 12'($urandom);
        y = 12'($urandom);
      end else begin
        x = near_axis(cur_cx);
        y = near_axis(cur_cy);
      end
      send_pixel(x, y, 24'($urandom));
    end
  endtask

  initial begin
    int per_phase;
    logic [11:0] ro;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    push = 1'b0; pixel_x = '0; pixel_y = '0;
    red_in = '0; green_in = '0; blue_in = '0;
    hold_left = 0; stall_cnt = 0;
    send_idle_pct = 37; recv_idle_pct = 83;
    cur_cx = '0; cur_cy = '0; cur_out = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: empty crop
    send_pixel(12'd0, 12'd0, 24'hFFFFFF);
    send_pixel(12'd4095, 12'd4095, 24'h000000);

    set_mask(12'd100, 12'd100, 12'd20, 12'd40);
    send_pixel(12'd100, 12'd100, 24'hFFFFFF);
    send_pixel(12'd60, 12'd60, 24'h000000);
    send_pixel(12'd139, 12'd139, 24'h123456);
    send_pixel(12'd59, 12'd100, 24'hABCDEF);
    send_pixel(12'd140, 12'd100, 24'hABCDEF);
    send_pixel(12'd100, 12'd59, 24'h010203);
    send_pixel(12'd100, 12'd140, 24'h010203);
    send_pixel(12'd120, 12'd100, 24'hFF00FF);
    send_pixel(12'd121, 12'd100, 24'h00FF00);
    send_pixel(12'd100, 12'd139, 24'h808080);
    send_pixel(12'd130, 12'd100, 24'h7F7F7F);

    // left and top limits clamp at zero
    set_mask(12'd0, 12'd0, 12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0, 24'hFFFFFF);
    send_pixel(12'd4094, 12'd4094, 24'h000000);
    send_pixel(12'd4095, 12'd4095, 24'h555555);

    // inner not below outer
    set_mask(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0, 24'hAAAAAA);
    send_pixel(12'd4095, 12'd4095, 24'h5A5A5A);
    send_pixel(12'd0, 12'd4095, 24'hA5A5A5);

    // full-size ramp over the whole image
    set_mask(12'd2048, 12'd2048, 12'd0, 12'd4095);
    send_random(250);

    per_phase = 200;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 37;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ro = (ph == 7) ? 12'd0 : (ph == 6) ? 12'd64 : 12'($urandom_range(64, 1));
      set_mask(12'($urandom), 12'($urandom),
               ($urandom_range(3) == 0) ? 12'($urandom_range(80)) : 12'(ro * 7 / 10), ro);
      if (ph == 6) hold_left = 300;
      send_random(per_phase);
    end

    push <= 1'b0;
    drain_and_settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rsam_pkg.sv
rtl/core/rsam_front.sv
rtl/core/rsam_queue.sv
rtl/core/rsam_back.sv
rtl/core/radial_soft_alpha_mask.sv
tb/rsam_checker.sv
tb/testbench.sv
